[rtl/core/bstp_pkg.sv]
// bstp_pkg: shared types, constants and defaults for the bound score table
// entry word layout, bound flags, controller command/status bundles
// no dependencies
package bstp_pkg;

  localparam int unsigned CLUSTER_COUNT_DEF = 4096;
  localparam int unsigned WAYS_DEF          = 4;

  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned GEN_W   = 6;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned MOVE_W  = 16;

  // bits of hash folded into the remainder per reduction step
  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MOD_STEPS = HASH_W / MOD_BITS;
  localparam int unsigned MCNT_W    = $clog2(MOD_STEPS + 1);

  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef enum logic [1:0] {
    FLAG_EXACT    = 2'd0,
    FLAG_LOWER    = 2'd1,
    FLAG_UPPER    = 2'd2,
    FLAG_TEMPERED = 2'd3
  } flag_e;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [MOVE_W-1:0]  move;
    logic [SCORE_W-1:0] score;
    logic               mp;
    logic [GEN_W-1:0]   gen;
    logic [DEPTH_W-1:0] depth;
    flag_e              flag;
    logic               valid;
  } entry_t;

  typedef struct packed {
    logic clr_step;
    logic cap;
    logic mod_step;
    logic rd_en;
    logic walk_en;
    logic wr_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic walk_done;
  } sts_t;

endpackage

[rtl/core/bound_score_table_probe_store.sv]
// bound_score_table_probe_store: top level of the clustered bound score table
// ties the controller (bstp_ctrl) to the datapath (bstp_datapath); uses bstp_pkg
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------------
//   in       | in        | in_valid_i/in_ready_o  | kind, hash, depth, window, result
//   out      | out       | out_valid_o/out_ready_i| hit, found score/move/present, tempered
//   cfg      | in        | cfg_valid_i/cfg_ready_o| search generation
//
// one item at a time: accept, index reduction (a mask when the cluster count is
// a power of two, else one byte of hash per step), one row read, a walk over the
// ways in order (up to WAYS, a probe may stop early), a write-back, a hand-off
// after reset a clear sweep writes every cluster row with in_ready_o low;
// configuration writes are taken throughout
// a result waits in the output register; the next item is taken only after its
// predecessor has been moved into that register
module bound_score_table_probe_store #(
  parameter int unsigned CLUSTER_COUNT = bstp_pkg::CLUSTER_COUNT_DEF,
  parameter int unsigned WAYS          = bstp_pkg::WAYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [bstp_pkg::HASH_W-1:0]         position_hash_i,
  input  logic [bstp_pkg::DEPTH_W-1:0]        search_depth_i,
  input  logic signed [bstp_pkg::SCORE_W-1:0] window_low_i,
  input  logic signed [bstp_pkg::SCORE_W-1:0] window_high_i,
  input  logic signed [bstp_pkg::SCORE_W-1:0] result_score_i,
  input  logic [bstp_pkg::MOVE_W-1:0]         result_move_i,
  input  logic                                result_move_present_i,
  input  logic                                best_tempered_i,
  input  logic                                any_tempered_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic signed [bstp_pkg::SCORE_W-1:0] found_score_o,
  output logic [bstp_pkg::MOVE_W-1:0]         found_move_o,
  output logic                                found_move_present_o,
  output logic                                stored_tempered_o,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bstp_pkg::GEN_W-1:0]          cfg_search_generation_i
);

  bstp_pkg::cmd_t cmd;
  bstp_pkg::sts_t sts;

  // generation register is always writable
  assign cfg_ready_o = 1'b1;

  bstp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bstp_datapath #(
    .CLUSTER_COUNT(CLUSTER_COUNT),
    .WAYS         (WAYS)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .kind_i                 (kind_i),
    .position_hash_i        (position_hash_i),
    .search_depth_i         (search_depth_i),
    .window_low_i           (window_low_i),
    .window_high_i          (window_high_i),
    .result_score_i         (result_score_i),
    .result_move_i          (result_move_i),
    .result_move_present_i  (result_move_present_i),
    .best_tempered_i        (best_tempered_i),
    .any_tempered_i         (any_tempered_i),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_search_generation_i(cfg_search_generation_i),
    .hit_o                  (hit_o),
    .found_score_o          (found_score_o),
    .found_move_o           (found_move_o),
    .found_move_present_o   (found_move_present_o),
    .stored_tempered_o      (stored_tempered_o)
  );

endmodule

[rtl/core/bstp_ram.sv]
// bstp_ram: generic single-port ram, one row written or read per cycle
// registered read data; no dependencies
module bstp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bstp_ctrl.sv]
// bstp_ctrl: sequencer for clear sweep, index reduction, read, way walk,
// write back and result hand-off; uses bstp_pkg
module bstp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bstp_pkg::sts_t sts_i,
  output bstp_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_WALK,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.cap = in_valid_i;
        if (in_valid_i) state_d = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mod_step = !sts_i.mod_done;
        if (sts_i.mod_done) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (sts_i.walk_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/bstp_datapath.sv]
// bstp_datapath: item registers, cluster index reduction, way walk logic,
// write-back row build and result registers; uses bstp_pkg and bstp_ram
module bstp_datapath #(
  parameter int unsigned CLUSTER_COUNT = bstp_pkg::CLUSTER_COUNT_DEF,
  parameter int unsigned WAYS          = bstp_pkg::WAYS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bstp_pkg::cmd_t                    cmd_i,
  output bstp_pkg::sts_t                    sts_o,
  input  logic                              kind_i,
  input  logic [bstp_pkg::HASH_W-1:0]       position_hash_i,
  input  logic [bstp_pkg::DEPTH_W-1:0]      search_depth_i,
  input  logic signed [bstp_pkg::SCORE_W-1:0] window_low_i,
  input  logic signed [bstp_pkg::SCORE_W-1:0] window_high_i,
  input  logic signed [bstp_pkg::SCORE_W-1:0] result_score_i,
  input  logic [bstp_pkg::MOVE_W-1:0]       result_move_i,
  input  logic                              result_move_present_i,
  input  logic                              best_tempered_i,
  input  logic                              any_tempered_i,
  input  logic                              cfg_valid_i,
  input  logic [bstp_pkg::GEN_W-1:0]        cfg_search_generation_i,
  output logic                              hit_o,
  output logic signed [bstp_pkg::SCORE_W-1:0] found_score_o,
  output logic [bstp_pkg::MOVE_W-1:0]       found_move_o,
  output logic                              found_move_present_o,
  output logic                              stored_tempered_o
);

  localparam int unsigned IW    = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
  localparam int unsigned RW    = IW + 1;
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W = WAYS * bstp_pkg::ENTRY_W;
  localparam bit IS_POW2 = ((CLUSTER_COUNT & (CLUSTER_COUNT - 1)) == 0);
  localparam int unsigned HW = bstp_pkg::HASH_W;
  localparam int unsigned SW = bstp_pkg::SCORE_W;
  localparam int unsigned DW = bstp_pkg::DEPTH_W;
  localparam int unsigned GW = bstp_pkg::GEN_W;

  // configuration and item registers
  logic [GW-1:0]            gen_q;
  logic                     kind_q;
  logic [bstp_pkg::TAG_W-1:0] tag_q;
  logic [DW-1:0]            depth_q;
  logic signed [SW-1:0]     alpha_q, beta_q;
  bstp_pkg::entry_t         new_q;
  logic                     bt_q;

  // index reduction
  logic [IW-1:0]            idx_q;
  logic [RW-1:0]            rem_q, rem_d;
  logic [HW-1:0]            sh_q;
  logic [bstp_pkg::MCNT_W-1:0] mcnt_q;
  logic [IW-1:0]            idx;

  // clear sweep and walk
  logic [IW-1:0]            clr_q;
  logic [WW-1:0]            way_q;

  // probe walk state
  logic                     hitw_q;
  logic [SW-1:0]            fscore_q;
  logic [bstp_pkg::MOVE_W-1:0] fmove_q;
  logic                     fmp_q;

  // store placement state
  logic                     match_q, match_wr_q, free_q, rep_q;
  logic [WW-1:0]            match_way_q, free_way_q, rep_way_q;
  logic [GW-1:0]            best_age_q;
  logic [DW-1:0]            best_depth_q;

  // result registers
  logic                     hit_q, omp_q, otemp_q;
  logic [SW-1:0]            oscore_q;
  logic [bstp_pkg::MOVE_W-1:0] omove_q;

  // ram
  logic [ROW_W-1:0]         rd_row, wr_row;
  logic                     ram_we;
  logic [IW-1:0]            ram_addr;
  bstp_pkg::entry_t         rows [WAYS];
  bstp_pkg::entry_t         e;

  bstp_pkg::flag_e          flag_in;
  logic                     tag_hit, shallow, closed, wide, p_stop, p_hit, way_last;
  logic signed [SW-1:0]     a_w, b_w;
  logic [GW-1:0]            age;
  logic                     do_write;
  logic [WW-1:0]            wway;

  // flag for a stored entry
  always_comb begin
    if (best_tempered_i) begin
      flag_in = bstp_pkg::FLAG_TEMPERED;
    end else if (any_tempered_i) begin
      flag_in = (result_score_i >= window_high_i || result_score_i >= window_low_i) ?
                bstp_pkg::FLAG_LOWER : bstp_pkg::FLAG_TEMPERED;
    end else if (result_score_i >= window_high_i) begin
      flag_in = bstp_pkg::FLAG_LOWER;
    end else if (result_score_i <= window_low_i) begin
      flag_in = bstp_pkg::FLAG_UPPER;
    end else begin
      flag_in = bstp_pkg::FLAG_EXACT;
    end
  end

  // remainder by the cluster count, one byte of hash per step
  always_comb begin
    logic [RW-1:0] t;
    t = rem_q;
    for (int j = 0; j < bstp_pkg::MOD_BITS; j++) begin
      t = {t[IW-1:0], sh_q[HW-1-j]};
      if (t >= RW'(CLUSTER_COUNT)) t = t - RW'(CLUSTER_COUNT);
    end
    rem_d = t;
  end

  assign idx = IS_POW2 ? idx_q : rem_q[IW-1:0];

  // way select and per-way decisions
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rows[i] = rd_row[i*bstp_pkg::ENTRY_W +: bstp_pkg::ENTRY_W];
    end
  end

  assign e        = rows[way_q];
  assign way_last = (way_q == WW'(WAYS - 1));
  assign tag_hit  = e.valid && (e.tag == tag_q);
  assign shallow  = (e.depth < depth_q);

  always_comb begin
    a_w = alpha_q;
    b_w = beta_q;
    if (e.flag == bstp_pkg::FLAG_LOWER && $signed(e.score) > a_w) a_w = $signed(e.score);
    if (e.flag == bstp_pkg::FLAG_UPPER && $signed(e.score) < b_w) b_w = $signed(e.score);
  end

  assign wide   = ({beta_q[SW-1], beta_q} - {alpha_q[SW-1], alpha_q}) > (SW+1)'(1)
                  && !(($signed({beta_q[SW-1], beta_q}) - $signed({alpha_q[SW-1], alpha_q}))
                       < $signed((SW+1)'(2)));
  assign closed = (a_w >= b_w);
  assign p_stop = tag_hit && (shallow || e.flag == bstp_pkg::FLAG_TEMPERED ||
                              e.flag == bstp_pkg::FLAG_EXACT || closed);
  assign p_hit  = tag_hit && !shallow && (e.flag != bstp_pkg::FLAG_TEMPERED) &&
                  (e.flag == bstp_pkg::FLAG_EXACT || closed) && e.mp;
  assign age    = gen_q - e.gen;

  assign sts_o.clr_last  = (clr_q == IW'(CLUSTER_COUNT - 1));
  assign sts_o.mod_done  = IS_POW2 || (mcnt_q == bstp_pkg::MCNT_W'(bstp_pkg::MOD_STEPS));
  assign sts_o.walk_done = way_last || ((kind_q == bstp_pkg::KIND_PROBE) && p_stop);

  // write-back target: matching way, else first free, else oldest shallowest
  assign do_write = cmd_i.wr_en && (kind_q == bstp_pkg::KIND_STORE) &&
                    (match_q ? match_wr_q : (free_q || rep_q));
  assign wway     = match_q ? match_way_q : (free_q ? free_way_q : rep_way_q);

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      wr_row[i*bstp_pkg::ENTRY_W +: bstp_pkg::ENTRY_W] =
        (WW'(i) == wway) ? new_q : rows[i];
    end
  end

  assign ram_we   = cmd_i.clr_step || do_write;
  assign ram_addr = cmd_i.clr_step ? clr_q : idx;

  bstp_ram #(
    .WIDTH(ROW_W),
    .DEPTH(CLUSTER_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (cmd_i.rd_en),
    .addr_i (ram_addr),
    .wdata_i(cmd_i.clr_step ? '0 : wr_row),
    .rdata_o(rd_row)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= '0;
      clr_q  <= '0;
      mcnt_q <= '0;
      way_q  <= '0;
    end else begin
      if (cfg_valid_i) gen_q <= cfg_search_generation_i;
      if (cmd_i.clr_step) clr_q <= clr_q + IW'(1);
      if (cmd_i.cap) begin
        mcnt_q <= '0;
        way_q  <= '0;
      end else begin
        if (cmd_i.mod_step) mcnt_q <= mcnt_q + bstp_pkg::MCNT_W'(1);
        if (cmd_i.walk_en && !way_last) way_q <= way_q + WW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q       <= kind_i;
      tag_q        <= position_hash_i[HW-1 -: bstp_pkg::TAG_W];
      depth_q      <= search_depth_i;
      alpha_q      <= window_low_i;
      beta_q       <= window_high_i;
      bt_q         <= best_tempered_i;
      new_q.valid  <= 1'b1;
      new_q.flag   <= flag_in;
      new_q.depth  <= search_depth_i;
      new_q.gen    <= gen_q;
      new_q.mp     <= result_move_present_i;
      new_q.score  <= result_score_i;
      new_q.move   <= result_move_i;
      new_q.tag    <= position_hash_i[HW-1 -: bstp_pkg::TAG_W];
      idx_q        <= position_hash_i[IW-1:0] & IW'(CLUSTER_COUNT - 1);
      rem_q        <= '0;
      sh_q         <= position_hash_i;
      hitw_q       <= 1'b0;
      fscore_q     <= '0;
      fmove_q      <= '0;
      fmp_q        <= 1'b0;
      match_q      <= 1'b0;
      free_q       <= 1'b0;
      rep_q        <= 1'b0;
      best_age_q   <= '0;
      best_depth_q <= search_depth_i;
    end
    if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      sh_q  <= sh_q << bstp_pkg::MOD_BITS;
    end
    if (cmd_i.walk_en && kind_q == bstp_pkg::KIND_PROBE && tag_hit) begin
      fscore_q <= e.score;
      fmove_q  <= e.move;
      fmp_q    <= e.mp;
      if (p_hit) hitw_q <= 1'b1;
      if (!p_stop && wide) begin
        alpha_q <= a_w;
        beta_q  <= b_w;
      end
    end
    if (cmd_i.walk_en && kind_q == bstp_pkg::KIND_STORE) begin
      if (tag_hit && !match_q) begin
        match_q     <= 1'b1;
        match_way_q <= way_q;
        match_wr_q  <= (e.depth <= depth_q);
      end
      if (!e.valid && !free_q) begin
        free_q     <= 1'b1;
        free_way_q <= way_q;
      end
      if (age > best_age_q) begin
        rep_q        <= 1'b1;
        rep_way_q    <= way_q;
        best_age_q   <= age;
        best_depth_q <= e.depth;
      end else if (age == best_age_q && e.depth <= best_depth_q) begin
        rep_q        <= 1'b1;
        rep_way_q    <= way_q;
        best_depth_q <= e.depth;
      end
    end
    if (cmd_i.out_load) begin
      hit_q    <= hitw_q;
      oscore_q <= fscore_q;
      omove_q  <= fmove_q;
      omp_q    <= fmp_q;
      otemp_q  <= (kind_q == bstp_pkg::KIND_STORE) && bt_q;
    end
  end

  assign hit_o                = hit_q;
  assign found_score_o        = oscore_q;
  assign found_move_o         = omove_q;
  assign found_move_present_o = omp_q;
  assign stored_tempered_o    = otemp_q;

  // a hit always carries a real move
  a_hit_has_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hitw_q && !cmd_i.cap) |-> fmp_q)
    else $error("hit without move present");

  // a store result reports no hit and empty found fields
  a_store_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && kind_q == bstp_pkg::KIND_STORE) |=>
      (!hit_o && found_score_o == '0 && !found_move_present_o))
    else $error("store result carries probe fields");

  // the table is written only by a clear sweep or a store
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cmd_i.clr_step || (cmd_i.wr_en && kind_q == bstp_pkg::KIND_STORE)))
    else $error("unexpected table write");

  // no lookup while the clear sweep runs
  a_no_read_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !(cmd_i.rd_en || cmd_i.walk_en || cmd_i.cap))
    else $error("lookup during clear sweep");

endmodule
